@@ rtl/indexed_pixel_row_streamer_top_defines.svh @@
// Assertion macros used by the checker file of the pixel row streamer.
`ifndef INDEXED_PIXEL_ROW_STREAMER_TOP_DEFINES_SVH
`define INDEXED_PIXEL_ROW_STREAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipr same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipr next-cycle check failed");

`endif

@@ rtl/ipr_pkg.sv @@
// Types, constants and helpers of the indexed pixel row streamer.
package ipr_pkg;

    localparam int PAL_ENTRIES   = 256;
    localparam int PAL_AW        = $clog2(PAL_ENTRIES);
    localparam int SCREEN_HEIGHT = 128;
    localparam logic [15:0] SCREEN_H16 = 16'(SCREEN_HEIGHT);

    // job queue depth, a power of two
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    localparam int WIN_BEATS  = 11;
    localparam int WIN_STEP_W = $clog2(WIN_BEATS);
    // command beats of the window sequence: CASET, RASET, RAMWR
    localparam logic [WIN_BEATS-1:0] WIN_CMD_MASK = 11'b100_0010_0001;

    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    localparam logic [1:0] REQ_PAL_WR = 2'd0;
    localparam logic [1:0] REQ_ROW    = 2'd1;
    localparam logic [1:0] REQ_DATA   = 2'd2;

    localparam logic [1:0] DEPTH_1BPP  = 2'd0;
    localparam logic [1:0] DEPTH_4BPP  = 2'd1;
    localparam logic [1:0] DEPTH_8BPP  = 2'd2;
    localparam logic [1:0] DEPTH_16BPP = 2'd3;

    localparam logic [1:0] ORIENT_UP   = 2'd0;
    localparam logic [1:0] ORIENT_LEFT = 2'd1;
    localparam logic [1:0] ORIENT_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
        logic [6:0]  start_x;
        logic [6:0]  start_y;
        logic [7:0]  pixel_count;
        logic [2:0]  first_offset;
        logic [1:0]  depth_mode;
        logic [7:0]  image_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        JOB_PAL_WR,
        JOB_WINDOW,
        JOB_MONO,
        JOB_IDX,
        JOB_RAW
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] color;
        logic [7:0]  idx_a;   // palette index, image byte or high byte
        logic [7:0]  idx_b;   // second index or held low byte
        logic [2:0]  pos;     // first bit for 1 bpp
        logic [3:0]  npix;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
    } job_t;

    typedef struct packed {
        logic vld;
        job_t job;
    } jobq_wr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WIN,
        BK_HI,
        BK_LO
    } bk_state_t;

    function automatic logic [15:0] to565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

@@ rtl/ipr_front.sv @@
// Front end: takes input beats, tracks the row state and issues jobs.
module ipr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ipr_pkg::in_item_t  item,
    input  logic               q_full,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_data,
    output logic               cfg_ready,
    output ipr_pkg::jobq_wr_t  jobq_wr
);

    logic       accept;
    logic [1:0] orient_reg;
    logic [7:0] left_reg,  left_next;
    logic [1:0] depth_reg, depth_next;
    logic [2:0] bpos_reg,  bpos_next;
    logic [7:0] held_reg,  held_next;
    logic       hold_reg,  hold_next;
    logic [1:0] dx, dy;
    logic [15:0] sy16, ylo, yhi;
    logic [3:0] room, npix;
    ipr_pkg::job_t job;
    logic       has_job;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= '0;
            left_reg   <= '0;
            depth_reg  <= '0;
            bpos_reg   <= '0;
            held_reg   <= '0;
            hold_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                orient_reg <= cfg_data;
            end
            if (accept)
            begin
                left_reg  <= left_next;
                depth_reg <= depth_next;
                bpos_reg  <= bpos_next;
                held_reg  <= held_next;
                hold_reg  <= hold_next;
            end
        end
    end

    // window offsets per orientation
    always_comb
    begin
        case (orient_reg)
            ipr_pkg::ORIENT_UP:
            begin
                dx = 2'd2;
                dy = 2'd3;
            end
            ipr_pkg::ORIENT_LEFT:
            begin
                dx = 2'd3;
                dy = 2'd2;
            end
            ipr_pkg::ORIENT_DOWN:
            begin
                dx = 2'd2;
                dy = 2'd1;
            end
            default:
            begin
                dx = 2'd1;
                dy = 2'd2;
            end
        endcase
    end

    assign sy16 = {9'b0, item.start_y};
    assign ylo  = (sy16 > ipr_pkg::SCREEN_H16) ? ipr_pkg::SCREEN_H16 : sy16;
    assign yhi  = (sy16 > ipr_pkg::SCREEN_H16) ? sy16 : ipr_pkg::SCREEN_H16;
    assign room = 4'd8 - {1'b0, bpos_reg};

    always_comb
    begin
        left_next  = left_reg;
        depth_next = depth_reg;
        bpos_next  = bpos_reg;
        held_next  = held_reg;
        hold_next  = hold_reg;
        job        = '0;
        has_job    = 1'b0;
        npix       = 4'd1;

        case (item.req_type)
            ipr_pkg::REQ_PAL_WR:
            begin
                has_job   = 1'b1;
                job.kind  = ipr_pkg::JOB_PAL_WR;
                job.idx_a = item.palette_index;
                job.color = item.palette_color;
            end
            ipr_pkg::REQ_ROW:
            begin
                has_job    = 1'b1;
                job.kind   = ipr_pkg::JOB_WINDOW;
                job.x0     = {9'b0, item.start_x} + {14'b0, dx};
                job.x1     = {9'b0, item.start_x} + {8'b0, item.pixel_count} + {14'b0, dx};
                job.y0     = ylo + {14'b0, dy};
                job.y1     = yhi + {14'b0, dy};
                left_next  = item.pixel_count;
                depth_next = item.depth_mode;
                bpos_next  = item.first_offset;
                held_next  = '0;
                hold_next  = 1'b0;
            end
            ipr_pkg::REQ_DATA:
            begin
                if (left_reg != 8'd0)
                begin
                    case (depth_reg)
                        ipr_pkg::DEPTH_1BPP:
                        begin
                            npix      = (left_reg < {4'b0, room}) ? left_reg[3:0] : room;
                            has_job   = 1'b1;
                            job.kind  = ipr_pkg::JOB_MONO;
                            job.idx_a = item.image_byte;
                            job.pos   = bpos_reg;
                            bpos_next = '0;
                        end
                        ipr_pkg::DEPTH_4BPP:
                        begin
                            has_job  = 1'b1;
                            job.kind = ipr_pkg::JOB_IDX;
                            if (!bpos_reg[0])
                            begin
                                npix      = (left_reg >= 8'd2) ? 4'd2 : 4'd1;
                                job.idx_a = {4'b0, item.image_byte[7:4]};
                                job.idx_b = {4'b0, item.image_byte[3:0]};
                            end
                            else
                            begin
                                job.idx_a = {4'b0, item.image_byte[3:0]};
                            end
                            bpos_next = '0;
                        end
                        ipr_pkg::DEPTH_8BPP:
                        begin
                            has_job   = 1'b1;
                            job.kind  = ipr_pkg::JOB_IDX;
                            job.idx_a = item.image_byte;
                        end
                        default:
                        begin
                            if (!hold_reg)
                            begin
                                held_next = item.image_byte;
                                hold_next = 1'b1;
                            end
                            else
                            begin
                                has_job   = 1'b1;
                                job.kind  = ipr_pkg::JOB_RAW;
                                job.idx_a = item.image_byte;
                                job.idx_b = held_reg;
                                held_next = '0;
                                hold_next = 1'b0;
                            end
                        end
                    endcase
                    job.npix = npix;
                    if (has_job)
                    begin
                        left_next = left_reg - {4'b0, npix};
                    end
                end
            end
            default:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    assign jobq_wr.vld = accept && has_job;
    assign jobq_wr.job = job;

endmodule

@@ rtl/ipr_jobq.sv @@
// Short job queue between the front and back ends.
module ipr_jobq (
    input  logic              clk,
    input  logic              rst_n,
    input  ipr_pkg::jobq_wr_t wr,
    input  logic              rd_en,
    output ipr_pkg::job_t     head,
    output logic              full,
    output logic              empty
);

    ipr_pkg::job_t                  slot_reg [ipr_pkg::JOBQ_DEPTH];
    logic [ipr_pkg::JOBQ_AW-1:0]    wr_ptr_reg;
    logic [ipr_pkg::JOBQ_AW-1:0]    rd_ptr_reg;
    logic [ipr_pkg::JOBQ_CW-1:0]    cnt_reg;
    logic                           do_wr;
    logic                           do_rd;

    assign full  = (cnt_reg == ipr_pkg::JOBQ_CW'(ipr_pkg::JOBQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr.vld && !full;
    assign do_rd = rd_en && !empty;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/ipr_back.sv @@
// Back end: palette store, byte sequencer and output register.
module ipr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ipr_pkg::job_t      q_head,
    input  logic               q_empty,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output ipr_pkg::out_item_t result
);

    ipr_pkg::bk_state_t             state_reg, state_next;
    ipr_pkg::job_t                  job_reg;
    logic [ipr_pkg::WIN_STEP_W-1:0] step_reg;
    logic [3:0]                     pix_cnt_reg;
    logic [2:0]                     pos_reg;
    logic [7:0]                     lo_reg;
    logic [15:0]                    mir0_reg, mir1_reg;
    logic [23:0]                    rd_data_reg;
    logic [23:0]                    pal_mem [ipr_pkg::PAL_ENTRIES];
    logic                           out_vld_reg;
    ipr_pkg::out_item_t             out_reg;

    logic                           emit_ok, emit_vld, load, mem_we;
    logic                           pix_last, win_last, cur_oor, mono_bit;
    logic [7:0]                     cur_idx;
    logic [ipr_pkg::PAL_AW-1:0]     rd_addr;
    logic [15:0]                    hi_val;
    logic [7:0]                     win_seq [ipr_pkg::WIN_BEATS];
    ipr_pkg::out_item_t             emit_beat;

    assign emit_ok  = !out_vld_reg || pop;
    assign pix_last = (pix_cnt_reg + 4'd1) == job_reg.npix;
    assign win_last = step_reg == ipr_pkg::WIN_STEP_W'(ipr_pkg::WIN_BEATS - 1);
    assign cur_idx  = pix_cnt_reg[0] ? job_reg.idx_b : job_reg.idx_a;
    assign cur_oor  = {1'b0, cur_idx} >= 9'(ipr_pkg::PAL_ENTRIES);
    assign mono_bit = job_reg.idx_a[~pos_reg];

    assign win_seq[0]  = ipr_pkg::CMD_CASET;
    assign win_seq[1]  = job_reg.x0[15:8];
    assign win_seq[2]  = job_reg.x0[7:0];
    assign win_seq[3]  = job_reg.x1[15:8];
    assign win_seq[4]  = job_reg.x1[7:0];
    assign win_seq[5]  = ipr_pkg::CMD_RASET;
    assign win_seq[6]  = job_reg.y0[15:8];
    assign win_seq[7]  = job_reg.y0[7:0];
    assign win_seq[8]  = job_reg.y1[15:8];
    assign win_seq[9]  = job_reg.y1[7:0];
    assign win_seq[10] = ipr_pkg::CMD_RAMWR;

    // pixel value shown in the high-byte beat
    always_comb
    begin
        case (job_reg.kind)
            ipr_pkg::JOB_MONO: hi_val = mono_bit ? mir1_reg : mir0_reg;
            ipr_pkg::JOB_IDX:  hi_val = cur_oor ? 16'h0 : ipr_pkg::to565(rd_data_reg);
            default:           hi_val = {job_reg.idx_a, job_reg.idx_b};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ipr_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        ipr_pkg::JOB_WINDOW: state_next = ipr_pkg::BK_WIN;
                        ipr_pkg::JOB_PAL_WR: state_next = ipr_pkg::BK_IDLE;
                        default:             state_next = ipr_pkg::BK_HI;
                    endcase
                end
            end
            ipr_pkg::BK_WIN:
            begin
                if (emit_ok && win_last)
                begin
                    state_next = ipr_pkg::BK_IDLE;
                end
            end
            ipr_pkg::BK_HI:
            begin
                if (emit_ok)
                begin
                    state_next = ipr_pkg::BK_LO;
                end
            end
            ipr_pkg::BK_LO:
            begin
                if (emit_ok)
                begin
                    state_next = pix_last ? ipr_pkg::BK_IDLE : ipr_pkg::BK_HI;
                end
            end
            default:
            begin
                state_next = ipr_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        load      = 1'b0;
        mem_we    = 1'b0;
        emit_vld  = 1'b0;
        emit_beat = '0;
        rd_addr   = cur_idx[ipr_pkg::PAL_AW-1:0];
        case (state_reg)
            ipr_pkg::BK_IDLE:
            begin
                load    = !q_empty;
                mem_we  = !q_empty && (q_head.kind == ipr_pkg::JOB_PAL_WR);
                rd_addr = q_head.idx_a[ipr_pkg::PAL_AW-1:0];
            end
            ipr_pkg::BK_WIN:
            begin
                emit_vld           = 1'b1;
                emit_beat.out_byte = win_seq[step_reg];
                emit_beat.is_data  = !ipr_pkg::WIN_CMD_MASK[step_reg];
                emit_beat.last     = win_last;
            end
            ipr_pkg::BK_HI:
            begin
                emit_vld           = 1'b1;
                emit_beat.out_byte = hi_val[15:8];
                emit_beat.is_data  = 1'b1;
            end
            ipr_pkg::BK_LO:
            begin
                emit_vld           = 1'b1;
                emit_beat.out_byte = lo_reg;
                emit_beat.is_data  = 1'b1;
                emit_beat.last     = pix_last;
                rd_addr            = job_reg.idx_b[ipr_pkg::PAL_AW-1:0];
            end
            default:
            begin
                emit_vld = 1'b0;
            end
        endcase
    end

    assign q_rd = load;

    // palette store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we && ({1'b0, q_head.idx_a} < 9'(ipr_pkg::PAL_ENTRIES)))
        begin
            pal_mem[q_head.idx_a[ipr_pkg::PAL_AW-1:0]] <= q_head.color;
        end
        rd_data_reg <= pal_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mem_we && (q_head.idx_a == 8'd0))
        begin
            mir0_reg <= q_head.color[15:0];
        end
        if (mem_we && (q_head.idx_a == 8'd1))
        begin
            mir1_reg <= q_head.color[15:0];
        end
        if (load)
        begin
            job_reg <= q_head;
        end
        if ((state_reg == ipr_pkg::BK_HI) && emit_ok)
        begin
            lo_reg <= hi_val[7:0];
        end
        if (emit_vld && emit_ok)
        begin
            out_reg <= emit_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ipr_pkg::BK_IDLE;
            step_reg    <= '0;
            pix_cnt_reg <= '0;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                step_reg    <= '0;
                pix_cnt_reg <= '0;
                pos_reg     <= q_head.pos;
            end
            if ((state_reg == ipr_pkg::BK_WIN) && emit_ok)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if ((state_reg == ipr_pkg::BK_LO) && emit_ok && !pix_last)
            begin
                pix_cnt_reg <= pix_cnt_reg + 4'd1;
                pos_reg     <= pos_reg + 3'd1;
            end
            if (emit_vld && emit_ok)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign empty  = !out_vld_reg;
    assign result = out_reg;

endmodule

@@ rtl/indexed_pixel_row_streamer_top.sv @@
// Top level of the indexed pixel row streamer.
//
//  channel   direction  handshake             payload
//  input     in         push / full           item   (ipr_pkg::in_item_t)
//  result    out        empty / pop           result (ipr_pkg::out_item_t)
//  config    in         cfg_valid / cfg_ready cfg_data (orientation, 2 bits)
//
// Front end takes one input beat per cycle while the 4-entry job queue has room.
// Back end sends one result beat per cycle while no result is held or pop is high,
// loading each job first: a window is 11 beats, a 1 bpp byte up to 16 beats,
// a 4/8/16 bpp pixel 2 beats. Palette writes use the store write port, no result.
// rst_n clears the row state, queue and sequencer; the palette store is not cleared.
// A full queue holds off push; a held result (pop low) stalls only the back end.
module indexed_pixel_row_streamer_top (
    input  logic               clk,
    input  logic               rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  ipr_pkg::in_item_t  item,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output ipr_pkg::out_item_t result,
    // orientation register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);

    ipr_pkg::jobq_wr_t jobq_wr;
    ipr_pkg::job_t     q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_rd;

    // front: classify beats, keep row bookkeeping, build jobs
    ipr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .q_full    (q_full),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .jobq_wr   (jobq_wr)
    );

    // decoupling queue; palette writes travel here too so lookups stay in order
    ipr_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (jobq_wr),
        .rd_en (q_rd),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: palette store, byte sequencer, output register
    ipr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full = q_full;

endmodule

@@ rtl/ipr_checker.sv @@
// Port-level checks of the pixel row streamer and their bind.
`include "indexed_pixel_row_streamer_top_defines.svh"

module ipr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input ipr_pkg::out_item_t result
);

    // a result held back must stay put
    `IPR_ASSERT_NEXT(a_hold, (!empty && !pop), (!empty && $stable(result)))

    // within one item the beats follow with no gap
    `IPR_ASSERT_NEXT(a_burst, (!empty && pop && !result.last), !empty)

    // command beats are only the three window commands
    `IPR_ASSERT_IMPL(a_cmd_code, (!empty && !result.is_data), (result.out_byte == ipr_pkg::CMD_CASET || result.out_byte == ipr_pkg::CMD_RASET || result.out_byte == ipr_pkg::CMD_RAMWR))

    // among command beats only RAMWR closes an item
    `IPR_ASSERT_IMPL(a_cmd_last, (!empty && !result.is_data), (result.last == (result.out_byte == ipr_pkg::CMD_RAMWR)))

endmodule

bind indexed_pixel_row_streamer_top ipr_checker u_ipr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
